>>> sv/sirs_pkg.sv
// Package: shared types, constants and helpers for the signed radix symbol converter.
package sirs_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int MAX_DIGITS  = 32;
    localparam int DIG_W       = $clog2(MAX_SYMBOLS);
    localparam int TOT_W       = $clog2(MAX_DIGITS) + 1;
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int CNT_W       = 5;
    localparam int TAB_W       = 64;
    localparam int VAL_W       = 32;
    localparam int SYM_W       = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH  = 2'd2;

    localparam logic [CNT_W-1:0] RST_COUNT = 5'd10;
    localparam logic [TAB_W-1:0] RST_LOW   = 64'h3736_3534_3332_3130;
    localparam logic [TAB_W-1:0] RST_HIGH  = 64'h0000_0000_0000_3938;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic table_ok;
        logic div_done;
        logic emit_last;
    } t_dp_sts;

    function automatic logic [SYM_W-1:0] table_byte(
        input logic [TAB_W-1:0] lo,
        input logic [TAB_W-1:0] hi,
        input logic [DIG_W-1:0] idx
    );
        logic [TAB_W-1:0] word;
        begin
            word = idx[3] ? hi : lo;
            return word[idx[2:0]*SYM_W +: SYM_W];
        end
    endfunction

    // Parallel check of the symbol table: count range, forbidden bytes, duplicates.
    function automatic logic table_valid(
        input logic [CNT_W-1:0] cnt,
        input logic [TAB_W-1:0] lo,
        input logic [TAB_W-1:0] hi
    );
        logic             ok;
        logic [SYM_W-1:0] ci;
        logic [SYM_W-1:0] cj;
        begin
            ok = (cnt >= CNT_W'(2)) && (cnt <= CNT_W'(MAX_SYMBOLS));
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                ci = table_byte(lo, hi, DIG_W'(i));
                if (CNT_W'(i) < cnt) begin
                    if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci == CHAR_NUL) begin
                        ok = 1'b0;
                    end
                    for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                        cj = table_byte(lo, hi, DIG_W'(j));
                        if (CNT_W'(j) < cnt && cj == ci) begin
                            ok = 1'b0;
                        end
                    end
                end
            end
            return ok;
        end
    endfunction

endpackage

>>> sv/sirs_ctrl.sv
// Controller: sequences load, digit division and symbol emission.
module sirs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sirs_pkg::t_dp_sts i_sts,
    output sirs_pkg::t_dp_cmd o_cmd,
    output logic              busy
);
    import sirs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_sts.table_ok) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start && i_sts.table_ok;
            end
            ST_DIV:  o_cmd.div  = 1'b1;
            ST_EMIT: o_cmd.emit = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // bad table: transfer taken, nothing started
    a_bad_table_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && start && !i_sts.table_ok) |=> (r_state == ST_IDLE))
        else $error("started on invalid table");

    a_emit_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_sts.emit_last) |=> (r_state == ST_EMIT))
        else $error("emission cut short");

endmodule

>>> sv/sirs_dp.sv
// Datapath: config registers, byte-wise radix divider, digit store, output register.
module sirs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sirs_pkg::TAB_W-1:0]        i_cfg_data,
    input  logic signed [sirs_pkg::VAL_W-1:0] i_value,
    input  sirs_pkg::t_dp_cmd                 i_cmd,
    output sirs_pkg::t_dp_sts                 o_sts,
    output logic                              o_valid,
    output logic [sirs_pkg::SYM_W-1:0]        o_symbol_byte,
    output logic                              o_last
);
    import sirs_pkg::*;

    localparam int STEP_BITS = 8;
    localparam int STEPS     = VAL_W / STEP_BITS;
    localparam int STEP_W    = $clog2(STEPS);

    logic [CNT_W-1:0] r_count;
    logic [TAB_W-1:0] r_low;
    logic [TAB_W-1:0] r_high;

    logic [VAL_W-1:0]  r_work,  n_work;
    logic [DIG_W-1:0]  r_rem,   n_rem;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [DIG_W-1:0]  r_store [MAX_DIGITS];

    logic                 r_valid, n_valid;
    logic [SYM_W-1:0]     r_sym,   n_sym;
    logic                 r_last,  n_last;

    logic [STEP_BITS-1:0] q_byte;
    logic [DIG_W-1:0]     step_rem;
    logic [DIG_W:0]       part;
    logic                 digit_end;
    logic [IDX_W-1:0]     rd_idx;
    logic [VAL_W-1:0]     mag;
    logic [VAL_W-1:0]     q_next;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= RST_COUNT;
            r_low   <= RST_LOW;
            r_high  <= RST_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                CFG_IDX_LOW:   r_low   <= i_cfg_data;
                CFG_IDX_HIGH:  r_high  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // eight restoring steps on the top byte of the running quotient
    always_comb begin
        step_rem = r_rem;
        q_byte   = '0;
        part     = '0;
        for (int b = 0; b < STEP_BITS; b++) begin
            part = {step_rem, r_work[VAL_W-1-b]};
            if (part >= (DIG_W+1)'(r_count)) begin
                part = part - (DIG_W+1)'(r_count);
                q_byte[STEP_BITS-1-b] = 1'b1;
            end
            step_rem = part[DIG_W-1:0];
        end
    end

    assign q_next    = {r_work[VAL_W-STEP_BITS-1:0], q_byte};
    assign digit_end = (r_step == STEP_W'(STEPS - 1));
    assign rd_idx    = IDX_W'(r_total - TOT_W'(1));
    assign mag       = i_value[VAL_W-1] ? (~i_value + VAL_W'(1)) : i_value;

    always_comb begin
        n_work  = r_work;
        n_rem   = r_rem;
        n_step  = r_step;
        n_total = r_total;
        n_valid = 1'b0;
        n_sym   = r_sym;
        n_last  = 1'b0;
        if (i_cmd.load) begin
            n_work  = mag;
            n_rem   = '0;
            n_step  = '0;
            n_total = '0;
            n_valid = i_value[VAL_W-1];
            n_sym   = CHAR_MINUS;
        end else if (i_cmd.div) begin
            n_work = q_next;
            n_rem  = digit_end ? '0 : step_rem;
            n_step = r_step + STEP_W'(1);
            if (digit_end) begin
                n_total = r_total + TOT_W'(1);
            end
        end else if (i_cmd.emit) begin
            n_total = r_total - TOT_W'(1);
            n_valid = 1'b1;
            n_last  = (r_total == TOT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_rem   <= '0;
            r_step  <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_work  <= n_work;
            r_rem   <= n_rem;
            r_step  <= n_step;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    // digit store: written at the end of each digit, read into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sym <= table_byte(r_low, r_high, r_store[rd_idx]);
        end else begin
            r_sym <= n_sym;
        end
        r_last <= n_last;
        if (i_cmd.div && digit_end) begin
            r_store[r_total[IDX_W-1:0]] <= step_rem;
        end
    end

    assign o_sts.table_ok  = table_valid(r_count, r_low, r_high);
    assign o_sts.div_done  = digit_end &&
                             ((q_next == '0) || (r_total == TOT_W'(MAX_DIGITS - 1)));
    assign o_sts.emit_last = (r_total == TOT_W'(1));

    assign o_valid       = r_valid;
    assign o_symbol_byte = r_sym;
    assign o_last        = r_last;

    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_total != '0))
        else $error("emit with empty digit store");

    a_rem_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div && digit_end) |=> (r_rem == '0 && r_step == '0))
        else $error("divider not rearmed after digit");

endmodule

>>> sv/signed_int_to_radix_symbols_top.sv
// Top level: signed 32-bit value to radix symbol run converter.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  input    | start / busy           | i_value[31:0] signed
//  result   | o_valid (strobe)       | o_symbol_byte[7:0], o_last
//  config   | i_cfg_we               | i_cfg_index[1:0], i_cfg_data[63:0]
//
// An input transfer takes place when start is high and busy is low.
// Digits come from a shared divider that works 8 dividend bits per cycle;
// each digit is one pass over all dividend bytes. An item with D digits
// (D = 1..32) goes through load, D passes in the divider and D emissions
// from the digit store. A negative value's '-' leaves on the cycle after
// the load. Results are one-cycle strobes; the receiver cannot stall them.
// Reset is synchronous, active low; it restores the default decimal table
// ("0".."9", count 10). An item seen with an invalid table is taken and
// produces no results; busy stays low.
module signed_int_to_radix_symbols_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sirs_pkg::TAB_W-1:0]        i_cfg_data,
    // input command
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sirs_pkg::VAL_W-1:0] i_value,
    // result strobe
    output logic                              o_valid,
    output logic [sirs_pkg::SYM_W-1:0]        o_symbol_byte,
    output logic                              o_last
);
    import sirs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // state machine: idle -> divide -> emit (one symbol per digit)
    sirs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // config registers, table check, divider, digit store and output register
    sirs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_symbol_byte (o_symbol_byte),
        .o_last        (o_last)
    );

endmodule
